// ===== rtl/rmc_pkg.sv =====
// types and constants shared by the region median color block
`default_nettype none

package rmc_pkg;

   localparam int unsigned NumLanes   = 4;
   localparam int unsigned NumBins    = 256;
   localparam int unsigned BinWidth   = 8;
   localparam int unsigned CountWidth = 25;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 13;

   localparam logic [CountWidth-1:0] CountLimit = 25'd16777216;

   localparam logic [CsrIdxWidth-1:0] CsrFrameWidth   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrFrameHeight  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRegionLeft   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrRegionTop    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrRegionRight  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrRegionBottom = 3'd5;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusBadRegion = 2'd1;
   localparam logic [1:0] StatusTooFew   = 2'd2;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] pixel_row;
      logic [7:0]  alpha;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [7:0]            median_alpha;
      logic [7:0]            median_red;
      logic [7:0]            median_green;
      logic [7:0]            median_blue;
      logic [CountWidth-1:0] pixel_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/rmc_stream_if.sv =====
// valid/ready stream channel carrying one payload item
`default_nettype none

interface rmc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/rmc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module rmc_ram #(
   parameter int unsigned WIDTH = 25,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ===== rtl/region_median_color.sv =====
// region_median_color: per-channel median of a rectangular frame region
//
// pixels enter on req_if (valid/ready); one result leaves on rsp_if after
// the pixel that carries frame_end. configuration is to be written through
// the csr_ port only while no frame result is being worked out; the block
// itself does not enforce this. a pixel inside the region has its bins
// read, then written back in the four 256-entry histogram rams.
// after the frame's last pixel the block evaluates the status, then one
// shared add/compare unit walks the four histograms one channel after the
// other, one bin a cycle, clearing each bin as it goes, before the result
// is offered. with a bad status or fewer than two pixels the rams are
// cleared in one sweep instead.
// req_if.ready stays low during all of this.
// after reset the rams are cleared in one sweep before the first pixel is
// taken. the result sits in an output register: pixels of the next frame
// are taken while it waits, and only the next result stalls until the
// receiver has taken the previous one.
`default_nettype none

module region_median_color
   import rmc_pkg::*;
#(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   rmc_stream_if.sink                   req_if,
   rmc_stream_if.source                 rsp_if,
   input  wire logic                    csr_write_enable,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_write_data
);

   localparam int unsigned DimWidth = $clog2(MAX_DIM + 1);
   localparam int unsigned CmpWidth = (DimWidth > 13) ? DimWidth : 13;
   localparam logic [CmpWidth-1:0] MaxDim = CmpWidth'(MAX_DIM);
   localparam int unsigned AddrWidth = $clog2(NumBins);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StUpdate = 3'd1;
   localparam logic [2:0] StEval   = 3'd2;
   localparam logic [2:0] StScan   = 3'd3;
   localparam logic [2:0] StClear  = 3'd4;
   localparam logic [2:0] StFinish = 3'd5;

   // configuration
   logic [12:0] frame_width_ff, frame_height_ff;
   logic [11:0] region_left_ff, region_top_ff, region_right_ff, region_bottom_ff;

   // control
   logic [2:0]            state_ff;
   logic [AddrWidth:0]    issue_ff;
   logic [1:0]            chan_ff;
   logic                  pend_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  proc_vld_ff;
   logic [BinWidth-1:0]   proc_bin_ff;
   logic [CountWidth-1:0] cum_ff;
   logic                  lo_found_ff, hi_found_ff;
   logic [BinWidth-1:0]   vlo_ff, vhi_ff;
   logic [CountWidth-2:0] lo_rank_ff, hi_rank_ff;
   logic [1:0]            status_ff;
   logic [BinWidth-1:0]   med_ff [NumLanes];
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff;

   // latched pixel
   logic [BinWidth-1:0]   pix_ff [NumLanes];
   logic                  frame_end_ff;

   // ram lanes
   logic [BinWidth-1:0]   req_byte [NumLanes];
   logic [AddrWidth-1:0]  rd_addr [NumLanes];
   logic [AddrWidth-1:0]  wr_addr [NumLanes];
   logic [CountWidth-1:0] wr_data [NumLanes];
   logic                  wr_en [NumLanes];
   logic [CountWidth-1:0] rd_data [NumLanes];

   logic                  accept;
   logic                  hit;
   logic                  region_bad;
   logic                  rsp_free;
   logic                  scan_done;
   logic [CountWidth-1:0] cum_in;
   logic [BinWidth:0]     med_sum;

   assign req_byte[0] = req_if.payload.alpha;
   assign req_byte[1] = req_if.payload.red;
   assign req_byte[2] = req_if.payload.green;
   assign req_byte[3] = req_if.payload.blue;

   assign req_if.ready = (state_ff == StIdle);
   assign accept       = req_if.valid && req_if.ready;

   assign hit = (req_if.payload.column >= region_left_ff)
             && (req_if.payload.column <= region_right_ff)
             && (req_if.payload.pixel_row >= region_top_ff)
             && (req_if.payload.pixel_row <= region_bottom_ff)
             && (count_ff < CountLimit);

   assign region_bad =
         (CmpWidth'(region_left_ff) >= CmpWidth'(frame_width_ff))
      || (CmpWidth'(region_left_ff) >= MaxDim)
      || (CmpWidth'(region_right_ff) >= CmpWidth'(frame_width_ff))
      || (CmpWidth'(region_right_ff) >= MaxDim)
      || (CmpWidth'(region_top_ff) >= CmpWidth'(frame_height_ff))
      || (CmpWidth'(region_top_ff) >= MaxDim)
      || (CmpWidth'(region_bottom_ff) >= CmpWidth'(frame_height_ff))
      || (CmpWidth'(region_bottom_ff) >= MaxDim)
      || (region_left_ff >= region_right_ff)
      || (region_top_ff >= region_bottom_ff);

   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign scan_done = issue_ff[AddrWidth] && !proc_vld_ff;
   assign cum_in    = cum_ff + rd_data[chan_ff];
   assign med_sum   = {1'b0, vlo_ff} + {1'b0, vhi_ff};

   // histogram rams
   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      always_comb begin
         rd_addr[i] = (state_ff == StIdle) ? req_byte[i] : issue_ff[AddrWidth-1:0];
         wr_addr[i] = (state_ff == StUpdate) ? pix_ff[i] : issue_ff[AddrWidth-1:0];
         wr_data[i] = (state_ff == StUpdate) ? rd_data[i] + 1'b1 : '0;
         wr_en[i]   = (state_ff == StUpdate) || (state_ff == StClear)
                   || ((state_ff == StScan) && (chan_ff == 2'(i))
                       && !issue_ff[AddrWidth]);
      end

      rmc_ram #(
         .WIDTH (CountWidth),
         .DEPTH (NumBins)
      ) u_hist (
         .clock         (clock),
         .write_enable  (wr_en[i]),
         .write_address (wr_addr[i]),
         .write_data    (wr_data[i]),
         .read_address  (rd_addr[i]),
         .read_data     (rd_data[i])
      );
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= 13'd4096;
         frame_height_ff  <= 13'd4096;
         region_left_ff   <= 12'd0;
         region_top_ff    <= 12'd0;
         region_right_ff  <= 12'd1;
         region_bottom_ff <= 12'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrFrameWidth:   frame_width_ff   <= csr_write_data;
            CsrFrameHeight:  frame_height_ff  <= csr_write_data;
            CsrRegionLeft:   region_left_ff   <= csr_write_data[11:0];
            CsrRegionTop:    region_top_ff    <= csr_write_data[11:0];
            CsrRegionRight:  region_right_ff  <= csr_write_data[11:0];
            CsrRegionBottom: region_bottom_ff <= csr_write_data[11:0];
            default: begin
            end
         endcase
      end
   end

   // pixel latch
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < NumLanes; i++) begin
            pix_ff[i] <= req_byte[i];
         end
         frame_end_ff <= req_if.payload.frame_end;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         issue_ff     <= '0;
         chan_ff      <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         proc_vld_ff  <= 1'b0;
         lo_found_ff  <= 1'b0;
         hi_found_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && !((state_ff == StFinish) && rsp_free)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            StIdle: begin
               if (accept) begin
                  if (hit) begin
                     state_ff <= StUpdate;
                  end else if (req_if.payload.frame_end) begin
                     state_ff <= StEval;
                  end
               end
            end

            StUpdate: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= frame_end_ff ? StEval : StIdle;
            end

            StEval: begin
               lo_rank_ff <= (CountWidth-1)'((count_ff - 1'b1) >> 1);
               hi_rank_ff <= count_ff[CountWidth-1:1];
               issue_ff   <= '0;
               pend_ff    <= 1'b1;
               for (int i = 0; i < NumLanes; i++) begin
                  med_ff[i] <= '0;
               end
               if (region_bad) begin
                  status_ff <= StatusBadRegion;
                  state_ff  <= StClear;
               end else if (count_ff < 25'd2) begin
                  status_ff <= StatusTooFew;
                  state_ff  <= StClear;
               end else begin
                  status_ff   <= StatusOk;
                  chan_ff     <= '0;
                  cum_ff      <= '0;
                  proc_vld_ff <= 1'b0;
                  lo_found_ff <= 1'b0;
                  hi_found_ff <= 1'b0;
                  state_ff    <= StScan;
               end
            end

            StScan: begin
               if (!issue_ff[AddrWidth]) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               proc_vld_ff <= !issue_ff[AddrWidth];
               proc_bin_ff <= issue_ff[AddrWidth-1:0];
               if (proc_vld_ff) begin
                  cum_ff <= cum_in;
                  if (!lo_found_ff && (cum_in > {1'b0, lo_rank_ff})) begin
                     lo_found_ff <= 1'b1;
                     vlo_ff      <= proc_bin_ff;
                  end
                  if (!hi_found_ff && (cum_in > {1'b0, hi_rank_ff})) begin
                     hi_found_ff <= 1'b1;
                     vhi_ff      <= proc_bin_ff;
                  end
               end
               if (scan_done) begin
                  med_ff[chan_ff] <= med_sum[BinWidth:1];
                  issue_ff        <= '0;
                  cum_ff          <= '0;
                  lo_found_ff     <= 1'b0;
                  hi_found_ff     <= 1'b0;
                  chan_ff         <= chan_ff + 1'b1;
                  if (chan_ff == 2'(NumLanes - 1)) begin
                     state_ff <= StFinish;
                  end
               end
            end

            StClear: begin
               if (issue_ff[AddrWidth-1:0] == AddrWidth'(NumBins - 1)) begin
                  issue_ff <= '0;
                  state_ff <= pend_ff ? StFinish : StIdle;
               end else begin
                  issue_ff <= issue_ff + 1'b1;
               end
            end

            StFinish: begin
               if (rsp_free) begin
                  rsp_ff.status       <= status_ff;
                  rsp_ff.median_alpha <= med_ff[0];
                  rsp_ff.median_red   <= med_ff[1];
                  rsp_ff.median_green <= med_ff[2];
                  rsp_ff.median_blue  <= med_ff[3];
                  rsp_ff.pixel_count  <= count_ff;
                  rsp_valid_ff        <= 1'b1;
                  count_ff            <= '0;
                  pend_ff             <= 1'b0;
                  state_ff            <= StIdle;
               end
            end

            default: begin
               state_ff <= StIdle;
            end
         endcase
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // checks
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StUpdate) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("pixel count did not step on a histogram update");

   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == StScan) && scan_done) |-> (lo_found_ff && hi_found_ff))
      else $error("median ranks not found by end of channel walk");

   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      hi_found_ff |-> lo_found_ff)
      else $error("upper rank found before lower rank");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == StFinish) && rsp_free && (status_ff != StatusOk))
      |=> (rsp_ff.median_alpha == '0 && rsp_ff.median_red == '0
           && rsp_ff.median_green == '0 && rsp_ff.median_blue == '0))
      else $error("non-ok result carries nonzero medians");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == StFinish) && rsp_free) |=> (count_ff == '0 && rsp_valid_ff))
      else $error("count not cleared when result was issued");

endmodule

`default_nettype wire

// ===== test/region_median_color_tb.sv =====
`timescale 1ns / 1ps
// testbench for region_median_color: directed and random frames checked against a histogram median predictor

module region_median_color_tb;
   import rmc_pkg::*;

   localparam int unsigned MaxDim        = 4096;
   localparam int unsigned PhaseCount    = 10;
   localparam int unsigned PhaseItems    = 93;
   localparam int unsigned SettleCycles  = 16;
   localparam int unsigned HoldCycles    = 3000;
   localparam int unsigned DrainCycles   = 1200;
   localparam int unsigned WatchdogLimit = 20000;

   localparam logic [CsrIdxWidth-1:0] CsrSpareLow  = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CsrSpareHigh = 3'd7;

   typedef enum logic {RowPixel, RowWrite} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CsrIdxWidth-1:0]  reg_index;
      logic [CsrDataWidth-1:0] reg_value;
      req_payload_type         pixel;
      bit                      literal;
      rsp_payload_type         result;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;

   rmc_stream_if #(.payload_type(req_payload_type)) req_if ();
   rmc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   region_median_color #(.MAX_DIM(MaxDim)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [12:0]           cfg_width  = 13'd4096;
   logic [12:0]           cfg_height = 13'd4096;
   logic [11:0]           cfg_left   = 12'd0;
   logic [11:0]           cfg_top    = 12'd0;
   logic [11:0]           cfg_right  = 12'd1;
   logic [11:0]           cfg_bottom = 12'd1;
   int unsigned           lane_bins [NumLanes][NumBins];
   logic [CountWidth-1:0] region_pixels = '0;

   rsp_payload_type pending_medians [$];
   stim_row_type    directed_rows [$];

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned hold_requests  = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;

   function automatic bit in_region(input logic [11:0] col, input logic [11:0] prow);
      return col >= cfg_left && col <= cfg_right && prow >= cfg_top && prow <= cfg_bottom;
   endfunction

   function automatic int unsigned lane_rank_value(input int lane, input int unsigned rank);
      int unsigned running;
      running = 0;
      for (int v = 0; v < NumBins; v++) begin
         running += lane_bins[lane][v];
         if (running > rank) return v;
      end
      return NumBins - 1;
   endfunction

   function automatic logic [7:0] lane_median(input int lane, input int unsigned n);
      int unsigned half;
      half = n / 2;
      if (n % 2 == 1) return 8'(lane_rank_value(lane, half));
      return 8'((lane_rank_value(lane, half - 1) + lane_rank_value(lane, half)) / 2);
   endfunction

   function automatic rsp_payload_type outcome(input logic [1:0] status,
                                               input logic [7:0] median,
                                               input logic [CountWidth-1:0] count);
      rsp_payload_type result;
      result.status       = status;
      result.median_alpha = median;
      result.median_red   = median;
      result.median_green = median;
      result.median_blue  = median;
      result.pixel_count  = count;
      return result;
   endfunction

   function automatic bit accumulate_pixel(input req_payload_type pixel,
                                           output rsp_payload_type result);
      logic [7:0]  lane_value [NumLanes];
      int unsigned eff_width;
      int unsigned eff_height;
      bit          bad;
      lane_value[0] = pixel.alpha;
      lane_value[1] = pixel.red;
      lane_value[2] = pixel.green;
      lane_value[3] = pixel.blue;
      if (in_region(pixel.column, pixel.pixel_row) && region_pixels < CountLimit) begin
         for (int lane = 0; lane < NumLanes; lane++) lane_bins[lane][lane_value[lane]]++;
         region_pixels++;
      end
      if (!pixel.frame_end) return 1'b0;
      eff_width  = (cfg_width < MaxDim) ? cfg_width : MaxDim;
      eff_height = (cfg_height < MaxDim) ? cfg_height : MaxDim;
      bad = cfg_left >= eff_width || cfg_right >= eff_width ||
            cfg_top >= eff_height || cfg_bottom >= eff_height ||
            cfg_left >= cfg_right || cfg_top >= cfg_bottom;
      if (bad) begin
         result = outcome(StatusBadRegion, 8'd0, region_pixels);
      end else if (region_pixels < 2) begin
         result = outcome(StatusTooFew, 8'd0, region_pixels);
      end else begin
         result.status       = StatusOk;
         result.median_alpha = lane_median(0, region_pixels);
         result.median_red   = lane_median(1, region_pixels);
         result.median_green = lane_median(2, region_pixels);
         result.median_blue  = lane_median(3, region_pixels);
         result.pixel_count  = region_pixels;
      end
      foreach (lane_bins[lane, bin]) lane_bins[lane][bin] = 0;
      region_pixels = '0;
      return 1'b1;
   endfunction

   function automatic void add_write(input logic [CsrIdxWidth-1:0] index,
                                     input logic [CsrDataWidth-1:0] value);
      stim_row_type entry;
      entry.kind      = RowWrite;
      entry.reg_index = index;
      entry.reg_value = value;
      entry.pixel     = '0;
      entry.literal   = 1'b0;
      entry.result    = '0;
      directed_rows.push_back(entry);
   endfunction

   function automatic void add_pixel(input logic [11:0] col, input logic [11:0] prow,
                                     input logic [7:0] a, input logic [7:0] r,
                                     input logic [7:0] g, input logic [7:0] b,
                                     input logic fe, input bit literal = 1'b0,
                                     input rsp_payload_type result = '0);
      stim_row_type entry;
      entry.kind            = RowPixel;
      entry.reg_index       = '0;
      entry.reg_value       = '0;
      entry.pixel.column    = col;
      entry.pixel.pixel_row = prow;
      entry.pixel.alpha     = a;
      entry.pixel.red       = r;
      entry.pixel.green     = g;
      entry.pixel.blue      = b;
      entry.pixel.frame_end = fe;
      entry.literal         = literal;
      entry.result          = result;
      directed_rows.push_back(entry);
   endfunction

   function automatic logic [11:0] pick_coord(input logic [11:0] lo, input logic [11:0] hi);
      case ($urandom_range(9))
         0: return lo;
         1: return hi;
         2: return lo - 12'd1;
         3: return hi + 12'd1;
         4: return 12'($urandom_range(4095));
         default: return 12'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(120, 136));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic drive_pixel(input req_payload_type pixel, input bit literal,
                              input rsp_payload_type literal_result);
      rsp_payload_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= pixel;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (accumulate_pixel(pixel, predicted))
         pending_medians.push_back(literal ? literal_result : predicted);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIdxWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         CsrFrameWidth:   cfg_width  = value;
         CsrFrameHeight:  cfg_height = value;
         CsrRegionLeft:   cfg_left   = value[11:0];
         CsrRegionTop:    cfg_top    = value[11:0];
         CsrRegionRight:  cfg_right  = value[11:0];
         CsrRegionBottom: cfg_bottom = value[11:0];
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : rsp_pacing
      int unsigned holds_done;
      int unsigned waited;
      holds_done   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            for (waited = 0; waited < HoldCycles; waited++) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_medians.size() == 0) begin
            $error("result with no frame pending");
            mismatch_count++;
         end else begin
            want = pending_medians.pop_front();
            check_field("status", want.status, rsp_if.payload.status);
            check_field("median_alpha", want.median_alpha, rsp_if.payload.median_alpha);
            check_field("median_red", want.median_red, rsp_if.payload.median_red);
            check_field("median_green", want.median_green, rsp_if.payload.median_green);
            check_field("median_blue", want.median_blue, rsp_if.payload.median_blue);
            check_field("pixel_count", want.pixel_count, rsp_if.payload.pixel_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
         $display("region_median_color test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_payload_type pixel;
      int unsigned     width;
      int unsigned     height;
      int unsigned     span_w;
      int unsigned     span_h;
      logic [11:0]     left;
      logic [11:0]     top;
      logic [11:0]     right;
      logic [11:0]     bottom;
      int unsigned     items;
      int unsigned     length;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      foreach (lane_bins[lane, bin]) lane_bins[lane][bin] = 0;

      // default region is the 2x2 corner
      add_pixel(12'd0, 12'd0, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
      add_pixel(12'd1, 12'd1, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1,
                outcome(StatusOk, 8'd127, 25'd2));
      add_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
                outcome(StatusTooFew, 8'd0, 25'd0));
      add_pixel(12'd1, 12'd0, 8'd77, 8'd66, 8'd55, 8'd44, 1'b1, 1'b1,
                outcome(StatusTooFew, 8'd0, 25'd1));
      // bottom right corner of the largest frame
      add_write(CsrRegionLeft, 13'd4093);
      add_write(CsrRegionTop, 13'd4093);
      add_write(CsrRegionRight, 13'd4095);
      add_write(CsrRegionBottom, 13'd4095);
      add_pixel(12'd4093, 12'd4093, 8'd0, 8'd1, 8'd2, 8'd3, 1'b0);
      add_pixel(12'd4094, 12'd4094, 8'd200, 8'd100, 8'd50, 8'd25, 1'b0);
      add_pixel(12'd4092, 12'd4095, 8'd9, 8'd9, 8'd9, 8'd9, 1'b0);
      add_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      // region reaches past the frame edge
      add_write(CsrFrameWidth, 13'd4095);
      add_pixel(12'd4094, 12'd4094, 8'd1, 8'd2, 8'd3, 8'd4, 1'b1, 1'b1,
                outcome(StatusBadRegion, 8'd0, 25'd1));
      add_write(CsrFrameWidth, 13'd0);
      add_write(CsrFrameHeight, 13'd8191);
      add_pixel(12'd4093, 12'd4093, 8'd5, 8'd6, 8'd7, 8'd8, 1'b1, 1'b1,
                outcome(StatusBadRegion, 8'd0, 25'd1));
      add_write(CsrFrameWidth, 13'd8191);
      add_write(CsrFrameHeight, 13'd0);
      add_pixel(12'd4095, 12'd4093, 8'd5, 8'd6, 8'd7, 8'd8, 1'b1, 1'b1,
                outcome(StatusBadRegion, 8'd0, 25'd1));
      // zero width column region
      add_write(CsrFrameHeight, 13'd4096);
      add_write(CsrRegionLeft, 13'd5);
      add_write(CsrRegionRight, 13'd5);
      add_write(CsrRegionTop, 13'd0);
      add_pixel(12'd5, 12'd0, 8'd10, 8'd20, 8'd30, 8'd40, 1'b0);
      add_pixel(12'd5, 12'd4095, 8'd50, 8'd60, 8'd70, 8'd80, 1'b1, 1'b1,
                outcome(StatusBadRegion, 8'd0, 25'd2));
      // rows out of order
      add_write(CsrRegionLeft, 13'd0);
      add_write(CsrRegionRight, 13'd4095);
      add_write(CsrRegionTop, 13'd10);
      add_write(CsrRegionBottom, 13'd3);
      add_pixel(12'd0, 12'd10, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 1'b1,
                outcome(StatusBadRegion, 8'd0, 25'd0));
      // spare indexes ignored, wide values masked to full frame
      add_write(CsrSpareLow, 13'd0);
      add_write(CsrSpareHigh, 13'd0);
      add_write(CsrRegionTop, 13'h1000);
      add_write(CsrRegionRight, 13'h1FFF);
      add_write(CsrRegionBottom, 13'h1FFF);
      add_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      add_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      add_pixel(12'd2048, 12'd1, 8'd10, 8'd20, 8'd30, 8'd40, 1'b0);
      add_pixel(12'd7, 12'd4000, 8'd11, 8'd21, 8'd31, 8'd41, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowWrite) begin
            settle();
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            drive_pixel(directed_rows[i].pixel, directed_rows[i].literal,
                        directed_rows[i].result);
         end
      end

      for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
         settle();
         case (phase)
            0: begin
               width = 4096; height = 4096;
               left = 12'd0; top = 12'd0; right = 12'd4095; bottom = 12'd4095;
            end
            1: begin
               width = 8191; height = 8191;
               left = 12'd4090; top = 12'd4093; right = 12'd4095; bottom = 12'd4095;
            end
            5, 8: begin
               width  = $urandom_range(8191);
               height = $urandom_range(8191);
               left   = 12'($urandom);
               top    = 12'($urandom);
               right  = 12'($urandom);
               bottom = 12'($urandom);
            end
            default: begin
               width  = $urandom_range(2, 8191);
               height = $urandom_range(2, 8191);
               span_w = (width < MaxDim) ? width : MaxDim;
               span_h = (height < MaxDim) ? height : MaxDim;
               left   = 12'($urandom_range(0, span_w - 2));
               top    = 12'($urandom_range(0, span_h - 2));
               right  = 12'($urandom_range(left + 1, span_w - 1));
               bottom = 12'($urandom_range(top + 1, span_h - 1));
            end
         endcase
         write_register(CsrFrameWidth, 13'(width));
         write_register(CsrFrameHeight, 13'(height));
         write_register(CsrRegionLeft, {1'($urandom_range(1)), left});
         write_register(CsrRegionTop, {1'($urandom_range(1)), top});
         write_register(CsrRegionRight, {1'($urandom_range(1)), right});
         write_register(CsrRegionBottom, {1'($urandom_range(1)), bottom});

         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 23; rsp_stall_pct = 23; end
         endcase
         // long receiver hold-off so the output register fills and input stalls
         if (phase == 2) hold_requests++;

         items = 0;
         while (items < PhaseItems) begin
            length = ($urandom_range(99) < 10) ? $urandom_range(1, 2) : $urandom_range(3, 16);
            for (int unsigned k = 1; k <= length; k++) begin
               pixel.column    = pick_coord(cfg_left, cfg_right);
               pixel.pixel_row = pick_coord(cfg_top, cfg_bottom);
               pixel.alpha     = pick_byte();
               pixel.red       = pick_byte();
               pixel.green     = pick_byte();
               pixel.blue      = pick_byte();
               pixel.frame_end = (k == length);
               items++;
               drive_pixel(pixel, 1'b0, '0);
            end
         end
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("region_median_color test passed");
      end else begin
         $display("region_median_color test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rmc_pkg.sv
rtl/rmc_stream_if.sv
rtl/rmc_ram.sv
rtl/region_median_color.sv
test/region_median_color_tb.sv
